// File: rtl/shp_pkg.sv
package shp_pkg;

    localparam int NODES = 64;
    localparam int EDGES = 256;
    localparam int NODE_W = 6;
    localparam int EDGE_AW = $clog2(EDGES);
    localparam int ECNT_W = EDGE_AW + 1;
    localparam int DIST_W = 40;
    localparam int WGT_W = 32;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_NODE  = 2'd1,
        MODE_EDGE  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [WGT_W-1:0]  weight;
    } edge_ent_t;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] parent;
    } node_ent_t;

endpackage

// File: rtl/shortest_path_search.sv
// Shortest-path engine over a stored graph of up to 64 nodes and 256 directed edges.
// Each input transfer is one command chosen by s_tuser: clear, add node, add edge or
// query. A query runs Dijkstra's method out of an edge RAM and a node RAM, with a
// third RAM as the path stack: every settled node costs a scan of the node RAM plus
// a read of each stored edge, with an update step for each edge leaving that node.
// The path is then traced back through the parent entries and sent start first, one
// transfer per path node, with m_tlast on the end node; each stack entry is read only
// once the output register is free. A query that finds no path sends one transfer
// with found clear. No new command is taken while a query is running.
module shortest_path_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node id, edge source, edge target, edge length, traffic weight, query source,
    // query target
    input  logic [71:0] s_tdata,
    // mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // total_distance, path_node
    output logic [47:0] m_tdata,
    // found
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE_WR, ST_Q_INIT, ST_SCAN, ST_DECIDE, ST_RELAX_RD, ST_RELAX_EDGE,
        ST_RELAX_UPD, ST_RESULT, ST_FAIL, ST_TOT_RD, ST_TOT_WAIT, ST_WALK, ST_WALK_WAIT,
        ST_POP_RD, ST_POP_WAIT
    } state_t;

    localparam int NW = shp_pkg::NODE_W;
    localparam int DW = shp_pkg::DIST_W;
    localparam int SCNT_W = NW + 1;

    state_t state_reg;

    logic [shp_pkg::NODES-1:0] present_reg, reached_reg, settled_reg;
    logic [shp_pkg::ECNT_W-1:0] edge_count_reg, k_reg;
    logic [SCNT_W-1:0] scan_cnt_reg, depth_reg;

    logic [NW-1:0] from_reg, to_reg, s_reg, e_reg, u_reg, dst_reg, cur_reg, rd_idx_reg;
    logic [23:0] dist_in_reg;
    logic [15:0] tf_in_reg;
    logic [shp_pkg::WGT_W-1:0] w_reg;
    logic [DW-1:0] min_dist_reg, best_u_reg, total_reg;
    logic have_reg, rd_pend_reg;

    logic m_valid_reg, out_found_reg, out_last_reg;
    logic [DW-1:0] out_dist_reg;
    logic [NW-1:0] out_node_reg;

    logic out_free;
    logic [39:0] product;
    logic [DW:0] sum;
    logic [DW-1:0] nd;

    // Edge RAM
    logic e_we;
    logic [shp_pkg::EDGE_AW-1:0] e_raddr;
    shp_pkg::edge_ent_t e_wdata, e_rdata;

    // Node RAM: best distance and parent
    logic n_we;
    logic [NW-1:0] n_waddr, n_raddr;
    shp_pkg::node_ent_t n_wdata, n_rdata;

    // Path stack RAM
    logic p_we;
    logic [NW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

    shp_ram #(.WIDTH($bits(shp_pkg::edge_ent_t)), .DEPTH(shp_pkg::EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(edge_count_reg[shp_pkg::EDGE_AW-1:0]),
        .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
    );

    shp_ram #(.WIDTH($bits(shp_pkg::node_ent_t)), .DEPTH(shp_pkg::NODES)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    shp_ram #(.WIDTH(NW), .DEPTH(shp_pkg::NODES)) u_path_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign product = dist_in_reg * tf_in_reg;
    assign sum = {1'b0, best_u_reg} + {{(DW - shp_pkg::WGT_W + 1){1'b0}}, w_reg};
    assign nd = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {2'b00, out_node_reg, out_dist_reg};
    assign m_tuser = out_found_reg;
    assign m_tlast = out_last_reg;

    always_comb
    begin
        e_we = (state_reg == ST_EDGE_WR) && (edge_count_reg != shp_pkg::ECNT_W'(shp_pkg::EDGES));
        // The product is at most 40 bits, so after the shift it always fits 32 bits.
        e_wdata = '{src: from_reg, dst: to_reg, weight: product[39:8]};
        e_raddr = k_reg[shp_pkg::EDGE_AW-1:0];

        n_we = 1'b0;
        n_waddr = dst_reg;
        n_wdata = '{cost: nd, parent: u_reg};
        if (state_reg == ST_Q_INIT)
        begin
            n_we = present_reg[s_reg] && present_reg[e_reg];
            n_waddr = s_reg;
            n_wdata = '{cost: '0, parent: s_reg};
        end
        else if (state_reg == ST_RELAX_UPD)
        begin
            n_we = !reached_reg[dst_reg] || (nd < n_rdata.cost);
        end

        unique case (state_reg)
            ST_SCAN:       n_raddr = scan_cnt_reg[NW-1:0];
            ST_RELAX_EDGE: n_raddr = e_rdata.dst;
            ST_TOT_RD:     n_raddr = e_reg;
            default:       n_raddr = cur_reg;
        endcase

        p_we = (state_reg == ST_WALK);
        p_waddr = depth_reg[NW-1:0];
        p_wdata = ((cur_reg != s_reg) && (depth_reg < SCNT_W'(shp_pkg::NODES - 1)))
                  ? cur_reg : s_reg;
        p_raddr = NW'(depth_reg - SCNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            present_reg <= '0;
            reached_reg <= '0;
            settled_reg <= '0;
            edge_count_reg <= '0;
            k_reg <= '0;
            scan_cnt_reg <= '0;
            depth_reg <= '0;
            have_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            // Scan compare on the node data returned in the cycle after each read.
            rd_pend_reg <= 1'b0;
            if (rd_pend_reg && reached_reg[rd_idx_reg] && !settled_reg[rd_idx_reg]
                && (!have_reg || n_rdata.cost < min_dist_reg))
            begin
                have_reg <= 1'b1;
                min_dist_reg <= n_rdata.cost;
                u_reg <= rd_idx_reg;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        from_reg <= s_tdata[11:6];
                        to_reg <= s_tdata[17:12];
                        dist_in_reg <= s_tdata[41:18];
                        tf_in_reg <= s_tdata[57:42];
                        s_reg <= s_tdata[63:58];
                        e_reg <= s_tdata[69:64];
                        unique case (shp_pkg::mode_t'(s_tuser))
                            shp_pkg::MODE_CLEAR:
                            begin
                                present_reg <= '0;
                                edge_count_reg <= '0;
                            end
                            shp_pkg::MODE_NODE:  present_reg[s_tdata[5:0]] <= 1'b1;
                            shp_pkg::MODE_EDGE:  state_reg <= ST_EDGE_WR;
                            shp_pkg::MODE_QUERY: state_reg <= ST_Q_INIT;
                        endcase
                    end
                end
                ST_EDGE_WR:
                begin
                    if (e_we)
                    begin
                        edge_count_reg <= edge_count_reg + shp_pkg::ECNT_W'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_Q_INIT:
                begin
                    if (present_reg[s_reg] && present_reg[e_reg])
                    begin
                        reached_reg <= '0;
                        reached_reg[s_reg] <= 1'b1;
                        settled_reg <= '0;
                        scan_cnt_reg <= '0;
                        have_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_FAIL;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg != SCNT_W'(shp_pkg::NODES))
                    begin
                        rd_pend_reg <= 1'b1;
                        rd_idx_reg <= scan_cnt_reg[NW-1:0];
                        scan_cnt_reg <= scan_cnt_reg + SCNT_W'(1);
                    end
                    else if (!rd_pend_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (!have_reg)
                    begin
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        settled_reg[u_reg] <= 1'b1;
                        best_u_reg <= min_dist_reg;
                        k_reg <= '0;
                        state_reg <= (u_reg == e_reg) ? ST_RESULT : ST_RELAX_RD;
                    end
                end
                ST_RELAX_RD:
                begin
                    if (k_reg == edge_count_reg)
                    begin
                        scan_cnt_reg <= '0;
                        have_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        k_reg <= k_reg + shp_pkg::ECNT_W'(1);
                        state_reg <= ST_RELAX_EDGE;
                    end
                end
                ST_RELAX_EDGE:
                begin
                    dst_reg <= e_rdata.dst;
                    w_reg <= e_rdata.weight;
                    state_reg <= (e_rdata.src == u_reg) ? ST_RELAX_UPD : ST_RELAX_RD;
                end
                ST_RELAX_UPD:
                begin
                    if (n_we)
                    begin
                        reached_reg[dst_reg] <= 1'b1;
                    end
                    state_reg <= ST_RELAX_RD;
                end
                ST_RESULT:  state_reg <= reached_reg[e_reg] ? ST_TOT_RD : ST_FAIL;
                ST_FAIL:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        out_found_reg <= 1'b0;
                        out_dist_reg <= '0;
                        out_node_reg <= '0;
                        out_last_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TOT_RD:  state_reg <= ST_TOT_WAIT;
                ST_TOT_WAIT:
                begin
                    total_reg <= n_rdata.cost;
                    cur_reg <= e_reg;
                    depth_reg <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    depth_reg <= depth_reg + SCNT_W'(1);
                    if ((cur_reg != s_reg) && (depth_reg < SCNT_W'(shp_pkg::NODES - 1)))
                    begin
                        state_reg <= ST_WALK_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_POP_RD;
                    end
                end
                ST_WALK_WAIT:
                begin
                    cur_reg <= n_rdata.parent;
                    state_reg <= ST_WALK;
                end
                ST_POP_RD:
                begin
                    // Reading only when the output register frees up means the returned
                    // entry never has to wait before it is sent.
                    if (out_free)
                    begin
                        depth_reg <= depth_reg - SCNT_W'(1);
                        state_reg <= ST_POP_WAIT;
                    end
                end
                ST_POP_WAIT:
                begin
                    m_valid_reg <= 1'b1;
                    out_found_reg <= 1'b1;
                    out_dist_reg <= total_reg;
                    out_node_reg <= p_rdata;
                    out_last_reg <= (depth_reg == '0);
                    state_reg <= (depth_reg == '0) ? ST_IDLE : ST_POP_RD;
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= shp_pkg::ECNT_W'(shp_pkg::EDGES))
        else $error("edge count beyond table size");

    a_settled_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (settled_reg & ~reached_reg) == '0)
        else $error("settled node that was never reached");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !out_found_reg |-> out_last_reg && out_dist_reg == '0)
        else $error("failed query result must be a single last transfer");

endmodule

// File: rtl/shp_ram.sv
module shp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
